// ----- sv/pwmms_pkg.sv -----
// Shared types, codes and constants for the position weight matrix scanner.
package pwmms_pkg;

    localparam int MOTIF_MAX_DEF = 32;

    localparam int WEIGHT_W = 16;
    localparam int CHAN_W   = 9;
    localparam int POS_W    = 5;
    localparam int LEN_W    = 6;
    localparam int INV_W    = 20;
    localparam int SCORE_W  = 24;
    localparam int BEST_W   = 23;
    localparam int COUNT_W  = 24;
    // four Q8.8 x Q1.8 products summed within one cell
    localparam int CELL_W   = 28;

    localparam logic [LEN_W-1:0]          LEN_RST    = 6'd8;
    localparam logic [INV_W-1:0]          INV_RST    = 20'd65536;
    localparam logic signed [SCORE_W-1:0] CUTOFF_RST = 24'sd58982;

    typedef enum logic [1:0] {
        OP_LOAD_FWD = 2'd0,
        OP_LOAD_REV = 2'd1,
        OP_COLUMN   = 2'd2,
        OP_END      = 2'd3
    } t_op;

    typedef enum logic {
        KIND_HIT     = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        REG_MOTIF_LENGTH  = 2'd0,
        REG_INV_MAX_SCORE = 2'd1,
        REG_HIT_CUTOFF    = 2'd2
    } t_reg;

    // base channels: 0 a, 1 c, 2 g, 3 t
    typedef logic [3:0][CHAN_W-1:0] t_col;

    typedef struct packed {
        logic [3:0][WEIGHT_W-1:0] fwd;
        logic [3:0][WEIGHT_W-1:0] rev;
    } t_wset;

    typedef struct packed {
        logic                col_shift;
        logic                rot_up;
        logic                rot_dn;
        logic                load_fwd;
        logic                load_rev;
        logic [1:0]          base;
        logic [WEIGHT_W-1:0] value;
    } t_cell_ctl;

    typedef struct packed {
        logic               vld;
        logic               is_end;
        logic [COUNT_W-1:0] start;
    } t_tag;

endpackage

// ----- sv/pwmms_in_if.sv -----
// Request channel carrying weight loads, sequence columns and end markers.
interface pwmms_in_if
    import pwmms_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 opcode;
    logic [POS_W-1:0]           weight_position;
    logic [1:0]                 weight_base;
    logic signed [WEIGHT_W-1:0] weight_value;
    logic [CHAN_W-1:0]          chan_a;
    logic [CHAN_W-1:0]          chan_c;
    logic [CHAN_W-1:0]          chan_g;
    logic [CHAN_W-1:0]          chan_t;

    modport source (
        output valid, opcode, weight_position, weight_base, weight_value,
               chan_a, chan_c, chan_g, chan_t,
        input  ready
    );
    modport sink (
        input  valid, opcode, weight_position, weight_base, weight_value,
               chan_a, chan_c, chan_g, chan_t,
        output ready
    );
endinterface

// ----- sv/pwmms_out_if.sv -----
// Result channel carrying hit reports and end-of-sequence summaries.
interface pwmms_out_if
    import pwmms_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      result_kind;
    logic [COUNT_W-1:0]        site_start;
    logic signed [SCORE_W-1:0] site_score;
    logic [COUNT_W-1:0]        hit_count;
    logic [BEST_W-1:0]         best_score;

    modport source (
        output valid, result_kind, site_start, site_score, hit_count, best_score,
        input  ready
    );
    modport sink (
        input  valid, result_kind, site_start, site_score, hit_count, best_score,
        output ready
    );
endinterface

// ----- sv/pwm_motif_scanner_unit.sv -----
// Top level of the two-strand position weight matrix scanner.
// Throughput: one request per cycle while the result side keeps up; the cell row,
// the adder tree and the scaling multiplier all advance together.
// A request passes the cell, adder tree, strand select, product and output registers.
// After a motif_length write the weights re-align by rotating the cell row, one
// position per cycle, with requests held off until the rotation is done.
// Reset (synchronous, active low) clears counters, best score, tags and registers.
module pwm_motif_scanner_unit
    import pwmms_pkg::*;
#(
    parameter int MOTIF_MAX = MOTIF_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pwmms_in_if.sink    i_in,
    pwmms_out_if.source o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int LW     = $clog2(MOTIF_MAX + 1);
    localparam int TLV    = $clog2(MOTIF_MAX);
    localparam int SUM_W  = CELL_W + TLV;
    localparam int PROD_W = SUM_W + INV_W + 1;
    localparam logic [LW-1:0] ALIGN_RST = (MOTIF_MAX < 8) ? LW'(MOTIF_MAX) : LW'(8);
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(8388607);
    localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(8388608);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // configuration
    logic [LEN_W-1:0]          r_len;
    logic [INV_W-1:0]          r_inv;
    logic signed [SCORE_W-1:0] r_cut;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RST;
            r_inv <= INV_RST;
            r_cut <= CUTOFF_RST;
        end else if (cfg_wr) begin
            unique case (t_reg'(paddr[3:2]))
                REG_MOTIF_LENGTH:  r_len <= pwdata[LEN_W-1:0];
                REG_INV_MAX_SCORE: r_inv <= pwdata[INV_W-1:0];
                REG_HIT_CUTOFF:    r_cut <= pwdata[SCORE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[3:2]))
            REG_MOTIF_LENGTH:  prdata = 32'(r_len);
            REG_INV_MAX_SCORE: prdata = 32'(r_inv);
            REG_HIT_CUTOFF:    prdata = 32'(r_cut);
            default:           prdata = '0;
        endcase
    end

    // motif length in use, clamped to 1..MOTIF_MAX
    logic [LW-1:0] len;

    always_comb begin
        if (r_len == '0) begin
            len = LW'(1);
        end else if (7'(r_len) > 7'(MOTIF_MAX)) begin
            len = LW'(MOTIF_MAX);
        end else begin
            len = LW'(r_len);
        end
    end

    // weights sit in cell (align - 1 - position) mod MOTIF_MAX; rotate to follow len
    logic [LW-1:0] r_align;
    logic          rot_up;
    logic          rot_dn;

    assign rot_up = r_align < len;
    assign rot_dn = r_align > len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align <= ALIGN_RST;
        end else if (rot_up) begin
            r_align <= r_align + LW'(1);
        end else if (rot_dn) begin
            r_align <= r_align - LW'(1);
        end
    end

    // request side
    logic adv;
    logic acc;
    t_op  op;
    logic r_ov;

    assign adv        = !r_ov || o_out.ready;
    assign i_in.ready = adv && !rot_up && !rot_dn;
    assign acc        = i_in.valid && i_in.ready;
    assign op         = t_op'(i_in.opcode);

    logic signed [7:0] tgt;
    logic              pos_ok;

    always_comb begin
        tgt = $signed({1'b0, 7'(r_align)}) - 8'sd1
            - $signed({3'b000, i_in.weight_position});
        if (tgt < 0) begin
            tgt = tgt + 8'(MOTIF_MAX);
        end
    end

    assign pos_ok = 7'(i_in.weight_position) < 7'(MOTIF_MAX);

    t_cell_ctl ctl;

    assign ctl.col_shift = acc && (op == OP_COLUMN);
    assign ctl.rot_up    = rot_up;
    assign ctl.rot_dn    = rot_dn;
    assign ctl.load_fwd  = acc && (op == OP_LOAD_FWD) && pos_ok;
    assign ctl.load_rev  = acc && (op == OP_LOAD_REV) && pos_ok;
    assign ctl.base      = i_in.weight_base;
    assign ctl.value     = i_in.weight_value;

    t_col in_col;

    assign in_col[0] = i_in.chan_a;
    assign in_col[1] = i_in.chan_c;
    assign in_col[2] = i_in.chan_g;
    assign in_col[3] = i_in.chan_t;

    // column count and window start
    logic [COUNT_W-1:0] r_seen;
    logic [COUNT_W-1:0] n_seen;
    logic               full;
    t_tag               r_t0;

    assign n_seen = (r_seen == COUNT_MAX) ? r_seen : r_seen + COUNT_W'(1);
    assign full   = n_seen >= COUNT_W'(len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_t0   <= '0;
        end else begin
            if (acc && op == OP_COLUMN) begin
                r_seen <= n_seen;
            end else if (acc && op == OP_END) begin
                r_seen <= '0;
            end
            if (adv) begin
                r_t0.vld    <= acc && ((op == OP_COLUMN && full) || op == OP_END);
                r_t0.is_end <= op == OP_END;
                r_t0.start  <= n_seen - COUNT_W'(len);
            end
        end
    end

    // cell row
    t_wset                    wset [MOTIF_MAX];
    t_col                     col  [MOTIF_MAX];
    logic signed [CELL_W-1:0] fsum [MOTIF_MAX];
    logic signed [CELL_W-1:0] rsum [MOTIF_MAX];

    for (genvar k = 0; k < MOTIF_MAX; k++) begin : g_cell
        pwmms_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_sel     (tgt == 8'(k)),
            .i_active  (LW'(k) < len),
            .i_wset_lo (wset[(k == 0) ? MOTIF_MAX - 1 : k - 1]),
            .i_wset_hi (wset[(k == MOTIF_MAX - 1) ? 0 : k + 1]),
            .i_col     ((k == 0) ? in_col : col[(k == 0) ? 0 : k - 1]),
            .o_wset    (wset[k]),
            .o_col     (col[k]),
            .o_fsum    (fsum[k]),
            .o_rsum    (rsum[k])
        );
    end

    logic signed [SUM_W-1:0] tree_f;
    logic signed [SUM_W-1:0] tree_r;
    t_tag                    tree_tag;

    pwmms_sum_tree #(
        .N  (MOTIF_MAX),
        .OW (SUM_W)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_f     (fsum),
        .i_r     (rsum),
        .i_tag   (r_t0),
        .o_f     (tree_f),
        .o_r     (tree_r),
        .o_tag   (tree_tag)
    );

    // strand select, then scale
    logic signed [SUM_W-1:0]  r_raw;
    logic signed [PROD_W-1:0] r_prod;
    t_tag                     r_t1;
    t_tag                     r_t2;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_raw  <= (tree_f > tree_r) ? tree_f : tree_r;
            r_prod <= r_raw * $signed({1'b0, r_inv});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
        end else if (adv) begin
            r_t1 <= tree_tag;
            r_t2 <= r_t1;
        end
    end

    // floor shift, saturate, compare, keep statistics
    logic signed [PROD_W-1:0]  shifted;
    logic signed [SCORE_W-1:0] score;
    logic                      hit;

    assign shifted = r_prod >>> 16;

    always_comb begin
        if (shifted > SAT_HI) begin
            score = SAT_HI[SCORE_W-1:0];
        end else if (shifted < SAT_LO) begin
            score = SAT_LO[SCORE_W-1:0];
        end else begin
            score = shifted[SCORE_W-1:0];
        end
    end

    assign hit = score >= r_cut;

    logic [COUNT_W-1:0] r_hits;
    logic [BEST_W-1:0]  r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits <= '0;
            r_best <= '0;
        end else if (adv && r_t2.vld) begin
            if (r_t2.is_end) begin
                r_hits <= '0;
                r_best <= '0;
            end else begin
                if (score > $signed({1'b0, r_best})) begin
                    r_best <= score[BEST_W-1:0];
                end
                if (hit && r_hits != COUNT_MAX) begin
                    r_hits <= r_hits + COUNT_W'(1);
                end
            end
        end
    end

    // output register
    t_kind                     r_kind;
    logic [COUNT_W-1:0]        r_start;
    logic signed [SCORE_W-1:0] r_score;
    logic [COUNT_W-1:0]        r_ohits;
    logic [BEST_W-1:0]         r_obest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_t2.vld && (r_t2.is_end || hit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_t2.is_end) begin
                r_kind  <= KIND_SUMMARY;
                r_start <= '0;
                r_score <= '0;
                r_ohits <= r_hits;
                r_obest <= r_best;
            end else begin
                r_kind  <= KIND_HIT;
                r_start <= r_t2.start;
                r_score <= score;
                r_ohits <= '0;
                r_obest <= '0;
            end
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.result_kind = r_kind;
    assign o_out.site_start  = r_start;
    assign o_out.site_score  = r_score;
    assign o_out.hit_count   = r_ohits;
    assign o_out.best_score  = r_obest;

    a_hit_meets_cutoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.result_kind == KIND_HIT) |-> (o_out.site_score >= r_cut))
        else $error("hit reported below cutoff");

    a_summary_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.result_kind == KIND_SUMMARY)
            |-> (o_out.site_start == '0 && o_out.site_score == '0))
        else $error("summary carries site fields");

    a_align_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_align != '0) && (r_align <= LW'(MOTIF_MAX)))
        else $error("weight alignment out of range");

    a_no_accept_while_rotating: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_align != len) |-> !acc)
        else $error("request taken during weight realignment");
endmodule

// ----- sv/pwmms_cell.sv -----
// One motif cell: a window column, its aligned weights and the per-cell dot products.
module pwmms_cell
    import pwmms_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic                     i_sel,
    input  logic                     i_active,
    input  t_wset                    i_wset_lo,
    input  t_wset                    i_wset_hi,
    input  t_col                     i_col,
    output t_wset                    o_wset,
    output t_col                     o_col,
    output logic signed [CELL_W-1:0] o_fsum,
    output logic signed [CELL_W-1:0] o_rsum
);
    t_wset                    r_w;
    t_col                     r_col;
    logic signed [CELL_W-1:0] r_fsum;
    logic signed [CELL_W-1:0] r_rsum;
    logic signed [CELL_W-1:0] n_fsum;
    logic signed [CELL_W-1:0] n_rsum;

    // products against the column arriving in this cell
    always_comb begin
        n_fsum = '0;
        n_rsum = '0;
        for (int b = 0; b < 4; b++) begin
            n_fsum = n_fsum + CELL_W'($signed(r_w.fwd[b]) * $signed({1'b0, i_col[b]}));
            n_rsum = n_rsum + CELL_W'($signed(r_w.rev[b]) * $signed({1'b0, i_col[b]}));
        end
        if (!i_active) begin
            n_fsum = '0;
            n_rsum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.col_shift) begin
            r_col  <= i_col;
            r_fsum <= n_fsum;
            r_rsum <= n_rsum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rot_up) begin
            r_w <= i_wset_lo;
        end else if (i_ctl.rot_dn) begin
            r_w <= i_wset_hi;
        end else begin
            if (i_sel && i_ctl.load_fwd) begin
                r_w.fwd[i_ctl.base] <= i_ctl.value;
            end
            if (i_sel && i_ctl.load_rev) begin
                r_w.rev[i_ctl.base] <= i_ctl.value;
            end
        end
    end

    assign o_wset = r_w;
    assign o_col  = r_col;
    assign o_fsum = r_fsum;
    assign o_rsum = r_rsum;
endmodule

// ----- sv/pwmms_sum_tree.sv -----
// Registered adder tree over the cell sums of both strands, with the request tag alongside.
module pwmms_sum_tree
    import pwmms_pkg::*;
#(
    parameter int N  = MOTIF_MAX_DEF,
    parameter int OW = CELL_W + $clog2(MOTIF_MAX_DEF)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic signed [CELL_W-1:0] i_f [N],
    input  logic signed [CELL_W-1:0] i_r [N],
    input  t_tag                     i_tag,
    output logic signed [OW-1:0]     o_f,
    output logic signed [OW-1:0]     o_r,
    output t_tag                     o_tag
);
    localparam int LV = $clog2(N);
    localparam int P  = 1 << LV;

    logic signed [OW-1:0] lf [P];
    logic signed [OW-1:0] lr [P];

    always_comb begin
        for (int i = 0; i < P; i++) begin
            lf[i] = '0;
            lr[i] = '0;
            if (i < N) begin
                lf[i] = OW'(i_f[i]);
                lr[i] = OW'(i_r[i]);
            end
        end
    end

    if (LV == 0) begin : g_flat
        assign o_f   = lf[0];
        assign o_r   = lr[0];
        assign o_tag = i_tag;
    end else begin : g_tree
        logic signed [OW-1:0] r_nf [1:P-1];
        logic signed [OW-1:0] r_nr [1:P-1];
        t_tag                 r_tag [LV];

        for (genvar i = 1; i < P; i++) begin : g_node
            if (2 * i >= P) begin : g_leaf
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_nf[i] <= lf[2*i-P] + lf[2*i-P+1];
                        r_nr[i] <= lr[2*i-P] + lr[2*i-P+1];
                    end
                end
            end else begin : g_inner
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_nf[i] <= r_nf[2*i] + r_nf[2*i+1];
                        r_nr[i] <= r_nr[2*i] + r_nr[2*i+1];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                for (int j = 0; j < LV; j++) begin
                    r_tag[j] <= '0;
                end
            end else if (i_en) begin
                r_tag[0] <= i_tag;
                for (int j = 1; j < LV; j++) begin
                    r_tag[j] <= r_tag[j-1];
                end
            end
        end

        assign o_f   = r_nf[1];
        assign o_r   = r_nr[1];
        assign o_tag = r_tag[LV-1];
    end
endmodule
